>>> src/occgrid_pkg.sv
// Shared codes and field widths for the occupancy grid block.
// Depends on nothing; imported by occupancy_grid_free_run.
package occgrid_pkg;

  localparam int CMD_W     = 2;
  localparam int POS_W     = 3;
  localparam int LEN_W     = 4;
  localparam int DIR_W     = 2;
  localparam int FREE_W    = 3;
  localparam int SIZE_W    = 4;
  localparam int CFG_IDX_W = 2;
  // Holds a run coordinate: start (up to 7) plus length (up to 15).
  localparam int COORD_W   = 5;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd6;
  localparam logic [FREE_W-1:0] FREE_MAX   = 3'd7;

endpackage

>>> src/occupancy_grid_free_run.sv
// Occupancy grid top level: grid flip-flops, one cell walker and its sequencer.
// Depends on occgrid_pkg for field widths, command, direction and register codes.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command: clear the grid,
//   mark or free a run of cells, or query free cells in a direction. A transfer
//   happens when in_valid is high and in_stall is low.
//   Output channel (out_valid / out_stall) returns one free_space per command,
//   zero for anything but a query, in command order.
//   Config port: cfg_we with cfg_index 0 (columns) or 1 (rows) and cfg_data.
//   A size write clears cells outside the new size in the following cycle.
// Timing:
//   A command steps one cell per cycle through the shared walker. The result
//   is loaded once the walk ends: at once for a clear, after its in-range
//   length for a run, after the free cells that it finds for a query.
//   in_stall is high from the transfer until the result is loaded.
// Reset clears every cell, sets both sizes to 6 and empties the output.
// While the receiver stalls, the result waits in the output register; the
// block takes the next command and holds its finished result until the
// output register frees.
module occupancy_grid_free_run #(
  parameter int GRID_MAX = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [occgrid_pkg::CMD_W-1:0]          cmd,
  input  logic [occgrid_pkg::POS_W-1:0]          pos_x,
  input  logic [occgrid_pkg::POS_W-1:0]          pos_y,
  input  logic                                   vertical,
  input  logic [occgrid_pkg::LEN_W-1:0]          run_length,
  input  logic [occgrid_pkg::DIR_W-1:0]          direction,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [occgrid_pkg::FREE_W-1:0]         free_space,
  input  logic                                   cfg_we,
  input  logic [occgrid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [occgrid_pkg::SIZE_W-1:0]         cfg_data
);
  import occgrid_pkg::*;

  localparam int RW = $clog2(GRID_MAX);

  typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_HOLD} state_t;

  state_t                 state;
  logic [CMD_W-1:0]       cmd_r;
  logic                   vert_r;
  logic                   dec_r;
  logic [COORD_W-1:0]     pos;
  logic [COORD_W-1:0]     fix;
  logic [LEN_W-1:0]       remain;
  logic [FREE_W-1:0]      count;
  logic                   skip;
  logic [SIZE_W-1:0]      grid_cols;
  logic [SIZE_W-1:0]      grid_rows;
  logic                   trim_pend;
  logic [GRID_MAX-1:0]    grid [GRID_MAX];

  logic [COORD_W-1:0]     lim_cols;
  logic [COORD_W-1:0]     lim_rows;
  logic [COORD_W-1:0]     walk_lim;
  logic [COORD_W-1:0]     probe;
  logic [COORD_W-1:0]     cell_x;
  logic [COORD_W-1:0]     cell_y;
  logic [GRID_MAX-1:0]    row_rd;
  logic                   cell_in;
  logic                   cell_occ;
  logic                   walk_end;
  logic                   done;
  logic                   is_run;
  logic                   write_en;
  logic                   out_free;
  logic                   accept;
  logic                   load;

  logic                   in_axis;
  logic [COORD_W-1:0]     in_walk;
  logic [COORD_W-1:0]     in_fix;
  logic                   in_dec;
  logic                   in_query;

  assign lim_cols = (COORD_W'(grid_cols) > COORD_W'(GRID_MAX)) ? COORD_W'(GRID_MAX)
                                                                : COORD_W'(grid_cols);
  assign lim_rows = (COORD_W'(grid_rows) > COORD_W'(GRID_MAX)) ? COORD_W'(GRID_MAX)
                                                                : COORD_W'(grid_rows);

  // Shared walker: one cell address, one bounds compare, one grid read per cycle
  assign walk_lim = vert_r ? lim_rows : lim_cols;
  assign probe    = dec_r ? pos - COORD_W'(1) : pos;
  assign walk_end = dec_r ? (pos == '0) : (pos >= walk_lim);
  assign cell_x   = vert_r ? fix : probe;
  assign cell_y   = vert_r ? probe : fix;
  assign cell_in  = (cell_x < lim_cols) && (cell_y < lim_rows);
  assign row_rd   = grid[cell_y[RW-1:0]];
  assign cell_occ = cell_in && row_rd[cell_x[RW-1:0]];
  assign is_run   = (cmd_r == CMD_MARK) || (cmd_r == CMD_FREE);

  always_comb begin
    case (cmd_r)
      CMD_CLEAR: done = 1'b1;
      CMD_QUERY: done = skip || walk_end || cell_occ;
      default:   done = skip || walk_end || (remain == '0);
    endcase
  end

  assign write_en = (state == ST_STEP) && !done && is_run && cell_in;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = out_free && (((state == ST_STEP) && done) || (state == ST_HOLD));

  // Decode a new command into walker start values
  assign in_query = (cmd == CMD_QUERY);
  assign in_axis  = in_query ? direction[1] : vertical;
  assign in_dec   = in_query && !direction[0];
  assign in_walk  = in_axis ? COORD_W'(pos_y) : COORD_W'(pos_x);
  assign in_fix   = in_axis ? COORD_W'(pos_x) : COORD_W'(pos_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      grid_cols  <= SIZE_RESET;
      grid_rows  <= SIZE_RESET;
      trim_pend  <= 1'b0;
    end else begin
      trim_pend <= cfg_we && ((cfg_index == REG_COLS) || (cfg_index == REG_ROWS));
      if (cfg_we) begin
        if (cfg_index == REG_COLS) begin
          grid_cols <= cfg_data;
        end else if (cfg_index == REG_ROWS) begin
          grid_rows <= cfg_data;
        end
      end

      if (out_valid && !out_stall && !load) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_r  <= cmd;
            vert_r <= in_axis;
            dec_r  <= in_dec;
            fix    <= in_fix;
            remain <= run_length;
            count  <= '0;
            pos    <= (in_query && direction[0]) ? in_walk + COORD_W'(1) : in_walk;
            if (in_query) begin
              skip <= (COORD_W'(pos_x) >= lim_cols) || (COORD_W'(pos_y) >= lim_rows);
            end else begin
              skip <= in_fix >= (in_axis ? lim_cols : lim_rows);
            end
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (done) begin
            if (out_free) begin
              free_space <= count;
              out_valid  <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end else begin
            pos    <= dec_r ? pos - COORD_W'(1) : pos + COORD_W'(1);
            remain <= remain - LEN_W'(1);
            if (cmd_r == CMD_QUERY && count != FREE_MAX) begin
              count <= count + FREE_W'(1);
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            free_space <= count;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Grid cells: cleared at reset and by a clear command, trimmed after a resize, written by the walker
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < GRID_MAX; r++) begin
        grid[r] <= '0;
      end
    end else begin
      if (trim_pend) begin
        for (int r = 0; r < GRID_MAX; r++) begin
          for (int c = 0; c < GRID_MAX; c++) begin
            if (COORD_W'(r) >= lim_rows || COORD_W'(c) >= lim_cols) begin
              grid[r][c] <= 1'b0;
            end
          end
        end
      end
      if (state == ST_STEP && cmd_r == CMD_CLEAR) begin
        for (int r = 0; r < GRID_MAX; r++) begin
          grid[r] <= '0;
        end
      end
      if (write_en) begin
        grid[cell_y[RW-1:0]][cell_x[RW-1:0]] <= (cmd_r == CMD_MARK);
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_STEP)
    else $error("accepted command did not start the walker");

  a_result_from_walker: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_STEP || $past(state) == ST_HOLD))
    else $error("result appeared without a finished command");

  a_hold_has_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_HOLD |-> out_valid)
    else $error("holding a result with an empty output register");

  a_query_only_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && cmd_r != CMD_QUERY) |-> count == '0)
    else $error("free count moved for a non-query command");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for occupancy_grid_free_run: directed and random grid commands.
// Depends on occgrid_pkg and the occupancy_grid_free_run RTL; carries its own grid predictor.
module tb_top;
  import occgrid_pkg::*;

  localparam int GRID_N     = 8;
  localparam int IDLE_LIMIT = 2000;

  // receiver stall patterns
  localparam int RX_NEVER = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;

  // register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             vert;
    logic [LEN_W-1:0] len;
    logic [DIR_W-1:0] dir;
  } grid_cmd_t;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     cmd        = '0;
  logic [POS_W-1:0]     pos_x      = '0;
  logic [POS_W-1:0]     pos_y      = '0;
  logic                 vertical   = 1'b0;
  logic [LEN_W-1:0]     run_length = '0;
  logic [DIR_W-1:0]     direction  = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [FREE_W-1:0]    free_space;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [SIZE_W-1:0]    cfg_data   = '0;

  occupancy_grid_free_run #(.GRID_MAX(GRID_N)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .vertical(vertical),
    .run_length(run_length), .direction(direction),
    .out_valid(out_valid), .out_stall(out_stall), .free_space(free_space),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted grid and sizes
  logic [GRID_N-1:0] cell_map [GRID_N];
  int                map_cols = int'(SIZE_RESET);
  int                map_rows = int'(SIZE_RESET);
  logic [FREE_W-1:0] free_expect_q [$];

  int  err_count    = 0;
  int  cmds_sent    = 0;
  int  results_seen = 0;
  int  burst_left   = 0;
  int  gap_max      = 0;
  bit  offering     = 1'b0;
  int  rx_mode      = RX_NEVER;
  int  holdoff_req  = 0;
  int  hold_left    = 0;
  int  idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int r = 0; r < GRID_N; r++) cell_map[r] = '0;
  end

  function automatic int clip_size(int s);
    return s > GRID_N ? GRID_N : s;
  endfunction

  function automatic void resize_map(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    int cols_in_use;
    int rows_in_use;
    if (idx == REG_COLS) map_cols = int'(val);
    else if (idx == REG_ROWS) map_rows = int'(val);
    else return;
    cols_in_use = clip_size(map_cols);
    rows_in_use = clip_size(map_rows);
    // drop every cell outside the new size
    for (int r = 0; r < GRID_N; r++)
      for (int c = 0; c < GRID_N; c++)
        if (r >= rows_in_use || c >= cols_in_use) cell_map[r][c] = 1'b0;
  endfunction

  function automatic void paint_run(grid_cmd_t c, logic v);
    int cols_in_use;
    int rows_in_use;
    int cx;
    int cy;
    cols_in_use = clip_size(map_cols);
    rows_in_use = clip_size(map_rows);
    for (int k = 0; k < int'(c.len); k++) begin
      cx = int'(c.x) + (c.vert ? 0 : k);
      cy = int'(c.y) + (c.vert ? k : 0);
      if (cx < cols_in_use && cy < rows_in_use) cell_map[cy][cx] = v;
    end
  endfunction

  function automatic logic [FREE_W-1:0] count_free(grid_cmd_t c);
    int cols_in_use;
    int rows_in_use;
    int qx;
    int qy;
    int n;
    int i;
    cols_in_use = clip_size(map_cols);
    rows_in_use = clip_size(map_rows);
    qx = int'(c.x);
    qy = int'(c.y);
    n = 0;
    if (qx >= cols_in_use || qy >= rows_in_use) return '0;
    case (c.dir)
      DIR_LEFT:  for (i = qx - 1; i >= 0 && !cell_map[qy][i]; i--) n++;
      DIR_RIGHT: for (i = qx + 1; i < cols_in_use && !cell_map[qy][i]; i++) n++;
      DIR_DOWN:  for (i = qy - 1; i >= 0 && !cell_map[i][qx]; i--) n++;
      DIR_UP:    for (i = qy + 1; i < rows_in_use && !cell_map[i][qx]; i++) n++;
      default: ;
    endcase
    return n > int'(FREE_MAX) ? FREE_MAX : n[FREE_W-1:0];
  endfunction

  function automatic logic [FREE_W-1:0] predict_free_space(grid_cmd_t c);
    logic [FREE_W-1:0] r;
    r = '0;
    case (c.op)
      CMD_CLEAR: for (int k = 0; k < GRID_N; k++) cell_map[k] = '0;
      CMD_MARK:  paint_run(c, 1'b1);
      CMD_FREE:  paint_run(c, 1'b0);
      CMD_QUERY: r = count_free(c);
      default: ;
    endcase
    return r;
  endfunction

  function automatic grid_cmd_t make_cmd(logic [CMD_W-1:0] op, int x, int y, int vert,
                                         int len, logic [DIR_W-1:0] dir);
    grid_cmd_t c;
    c.op   = op;
    c.x    = POS_W'(x);
    c.y    = POS_W'(y);
    c.vert = (vert != 0);
    c.len  = LEN_W'(len);
    c.dir  = dir;
    return c;
  endfunction

  function automatic grid_cmd_t random_cmd();
    grid_cmd_t c;
    int pick;
    pick   = $urandom_range(0, 99);
    c.op   = pick < 3 ? CMD_CLEAR : pick < 38 ? CMD_MARK : pick < 63 ? CMD_FREE : CMD_QUERY;
    c.x    = POS_W'($urandom_range(0, 7));
    c.y    = POS_W'($urandom_range(0, 7));
    c.vert = ($urandom_range(0, 1) != 0);
    // mostly runs that fit the grid, some far past its edge
    c.len  = ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(0, 8))
                                         : LEN_W'($urandom_range(9, 15));
    c.dir  = DIR_W'($urandom_range(0, 3));
    return c;
  endfunction

  task automatic send_cmd(grid_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0 && offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    offering   = 1'b1;
    cmd        <= c.op;
    pos_x      <= c.x;
    pos_y      <= c.y;
    vertical   <= c.vert;
    run_length <= c.len;
    direction  <= c.dir;
    do @(posedge clk); while (in_stall);
    free_expect_q.push_back(predict_free_space(c));
    cmds_sent++;
    burst_left--;
  endtask

  task automatic release_input();
    burst_left = 0;
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    release_input();
    while (free_expect_q.size() != 0) @(posedge clk);
    repeat (GRID_N + 4) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    resize_map(idx, val);
    // trim happens the cycle after the write
    repeat (2) @(posedge clk);
  endtask

  task automatic send_random(int n);
    repeat (n) send_cmd(random_cmd());
  endtask

  task automatic check_free_space(logic [FREE_W-1:0] actual);
    logic [FREE_W-1:0] want;
    results_seen++;
    if (free_expect_q.size() == 0) begin
      $display("%0t: free_space %0d arrived with no command pending", $time, actual);
      err_count++;
    end else begin
      want = free_expect_q.pop_front();
      if (actual !== want) begin
        $display("%0t: free_space mismatch, expected %0d, actual %0d", $time, want, actual);
        err_count++;
      end
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    logic stall_next;
    stall_next = 1'b0;
    if (!rst && out_valid && !out_stall) check_free_space(free_space);
    if (holdoff_req > 0) begin
      hold_left = holdoff_req;
      holdoff_req = 0;
    end
    if (hold_left > 0) begin
      stall_next = 1'b1;
      hold_left--;
    end else if (rx_mode != RX_NEVER && $urandom_range(0, 63) == 0) begin
      hold_left = $urandom_range(1, 12);
      stall_next = 1'b1;
    end else begin
      case (rx_mode)
        RX_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
        RX_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
        default:  stall_next = 1'b0;
      endcase
    end
    out_stall <= stall_next;
  end

  // end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("occupancy_grid_free_run test failed");
      $finish;
    end
  end

  task automatic test_empty_grid();
    rx_mode = RX_NEVER;
    gap_max = 0;
    send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 0, DIR_RIGHT));
    send_cmd(make_cmd(CMD_QUERY, 5, 5, 1, 15, DIR_LEFT));
    send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 7, DIR_UP));
    send_cmd(make_cmd(CMD_QUERY, 5, 5, 1, 8, DIR_DOWN));
    send_cmd(make_cmd(CMD_QUERY, 6, 2, 0, 0, DIR_RIGHT));
    send_cmd(make_cmd(CMD_QUERY, 2, 7, 0, 0, DIR_UP));
    send_cmd(make_cmd(CMD_CLEAR, 7, 7, 1, 15, DIR_UP));
    drain_results();
  endtask

  task automatic test_run_edges();
    rx_mode = RX_LIGHT;
    gap_max = 3;
    // run past the right edge
    send_cmd(make_cmd(CMD_MARK, 0, 2, 0, 8, DIR_LEFT));
    send_cmd(make_cmd(CMD_QUERY, 0, 3, 0, 0, DIR_DOWN));
    send_cmd(make_cmd(CMD_QUERY, 5, 1, 0, 0, DIR_UP));
    send_cmd(make_cmd(CMD_FREE, 2, 2, 0, 2, DIR_LEFT));
    send_cmd(make_cmd(CMD_QUERY, 2, 0, 0, 0, DIR_UP));
    // vertical run past the top edge
    send_cmd(make_cmd(CMD_MARK, 3, 0, 1, 15, DIR_RIGHT));
    send_cmd(make_cmd(CMD_QUERY, 0, 4, 0, 0, DIR_RIGHT));
    send_cmd(make_cmd(CMD_QUERY, 5, 4, 0, 0, DIR_LEFT));
    // zero length changes nothing
    send_cmd(make_cmd(CMD_MARK, 1, 1, 0, 0, DIR_DOWN));
    send_cmd(make_cmd(CMD_QUERY, 1, 0, 0, 0, DIR_UP));
    // fixed coordinate outside the grid
    send_cmd(make_cmd(CMD_MARK, 0, 7, 0, 8, DIR_DOWN));
    send_cmd(make_cmd(CMD_MARK, 6, 0, 1, 4, DIR_DOWN));
    send_cmd(make_cmd(CMD_QUERY, 5, 0, 1, 0, DIR_UP));
    send_cmd(make_cmd(CMD_FREE, 3, 1, 1, 3, DIR_UP));
    send_cmd(make_cmd(CMD_QUERY, 0, 2, 0, 0, DIR_RIGHT));
    send_cmd(make_cmd(CMD_QUERY, 3, 5, 0, 0, DIR_DOWN));
    send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0, DIR_LEFT));
    send_cmd(make_cmd(CMD_QUERY, 2, 2, 0, 0, DIR_LEFT));
    drain_results();
  endtask

  task automatic test_sizes();
    rx_mode = RX_LIGHT;
    gap_max = 2;
    write_size(REG_COLS, 4'd8);
    write_size(REG_ROWS, 4'd8);
    send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 0, DIR_RIGHT));
    send_cmd(make_cmd(CMD_MARK, 7, 0, 1, 8, DIR_LEFT));
    send_cmd(make_cmd(CMD_MARK, 0, 7, 0, 8, DIR_LEFT));
    send_cmd(make_cmd(CMD_MARK, 0, 1, 0, 8, DIR_LEFT));
    // shrink, then grow past storage: outer cells must come back free
    write_size(REG_COLS, 4'd3);
    write_size(REG_ROWS, 4'd3);
    send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 0, DIR_UP));
    write_size(REG_COLS, 4'd15);
    write_size(REG_ROWS, 4'd12);
    send_cmd(make_cmd(CMD_QUERY, 0, 7, 0, 0, DIR_RIGHT));
    send_cmd(make_cmd(CMD_QUERY, 7, 0, 0, 0, DIR_UP));
    send_cmd(make_cmd(CMD_QUERY, 1, 0, 0, 0, DIR_UP));
    write_size(REG_SPARE_A, 4'd5);
    write_size(REG_SPARE_B, 4'd10);
    send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 0, DIR_RIGHT));
    write_size(REG_COLS, 4'd0);
    send_cmd(make_cmd(CMD_MARK, 0, 0, 0, 8, DIR_LEFT));
    send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 0, DIR_UP));
    write_size(REG_COLS, 4'd1);
    write_size(REG_ROWS, 4'd1);
    send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 0, DIR_RIGHT));
    send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 0, DIR_DOWN));
    write_size(REG_COLS, 4'd6);
    write_size(REG_ROWS, 4'd6);
    drain_results();
  endtask

  task automatic test_random_phases();
    int cols_list [9] = '{6, 8, 1, 8, 4, 15, 0, 2, 8};
    int rows_list [9] = '{6, 8, 8, 1, 7, 12, 5, 3, 8};
    for (int p = 0; p < 9; p++) begin
      write_size(REG_COLS, SIZE_W'(cols_list[p]));
      write_size(REG_ROWS, SIZE_W'(rows_list[p]));
      rx_mode = p % 3;
      gap_max = (p % 2 == 1) ? 6 : 0;
      send_random(p == 6 ? 60 : 160);
      drain_results();
    end
  endtask

  task automatic test_receiver_holdoff();
    rx_mode = RX_NEVER;
    gap_max = 0;
    write_size(REG_COLS, 4'd8);
    write_size(REG_ROWS, 4'd8);
    // hold the output long enough that the block stalls its input
    holdoff_req = 300;
    send_random(40);
    drain_results();
    rx_mode = RX_LIGHT;
    send_random(20);
    drain_results();
    send_random(20);
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_grid();
    test_run_edges();
    test_sizes();
    test_random_phases();
    test_receiver_holdoff();
    drain_results();
    $display("Sent %0d grid commands and checked %0d free_space results.",
             cmds_sent, results_seen);
    $display("Covered sizes 0 to 15, ignored register indexes, input and output stalls.");
    if (err_count == 0) begin
      $display("occupancy_grid_free_run test passed");
    end else begin
      $display("occupancy_grid_free_run test failed");
    end
    $finish;
  end

endmodule

>>> occupancy_grid_free_run.f
src/occgrid_pkg.sv
src/occupancy_grid_free_run.sv
tb/tb_top.sv
